/* sv/fppm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fppm_pkg
// Types, constants and saturation helpers for the focal-plane to pixel map.
// ----------------------------------------------------------------------------
package fppm_pkg;

  // Field widths
  localparam int FP_W      = 24;  // focal-plane coordinate, Q8.16
  localparam int COEF_W    = 16;  // cosine / sine Q1.14, reciprocal scale Q7.9
  localparam int DIFF_W    = 25;  // position minus origin
  localparam int PROD_W    = 41;  // trig term
  localparam int ROT_W     = 42;  // rotated offset, Q.30
  localparam int SCL_W     = 59;  // scaled offset, Q.39
  localparam int RND_W     = 60;  // scaled offset after half-pixel adjust
  localparam int FRAC_SH   = 31;  // Q.39 down to Q.8
  localparam int PIX_W     = RND_W - FRAC_SH;  // unclamped detector pixel, Q.8
  localparam int IMG_W     = PIX_W + 1;        // unclamped image pixel, Q.8
  localparam int DET_OUT_W = 22;
  localparam int IMG_OUT_W = 23;

  // Minus one half pixel (Q.39) plus one half LSB of the Q.8 result
  localparam logic signed [RND_W-1:0] ROUND_ADJ =
    -(RND_W'(64'sd1) <<< 38) + (RND_W'(64'sd1) <<< 30);

  // Image geometry
  localparam int DET_WIDTH  = 2048;
  localparam int DET_HEIGHT = 2058;
  localparam int ROW_PAD    = 44;
  localparam int DARK_COLS  = 20;
  localparam int PIX_ONE    = 256;

  localparam logic signed [IMG_W-1:0] IMG_COL_D0 =
    IMG_W'((2 * DET_WIDTH + 3 * ROW_PAD - 1) * PIX_ONE);
  localparam logic signed [IMG_W-1:0] IMG_COL_D1 =
    IMG_W'((DET_WIDTH + ROW_PAD - 1) * PIX_ONE);
  localparam logic signed [IMG_W-1:0] IMG_COL_D2 =
    IMG_W'(ROW_PAD * PIX_ONE);
  localparam logic signed [IMG_W-1:0] IMG_COL_D3 =
    IMG_W'((DET_WIDTH + 3 * ROW_PAD) * PIX_ONE);
  localparam logic signed [IMG_W-1:0] IMG_ROW_D01 =
    IMG_W'((2 * DET_HEIGHT + 2 * DARK_COLS - 1) * PIX_ONE);

  // Saturation limits
  localparam logic signed [PIX_W-1:0] DET_HI = PIX_W'((64'sd1 <<< (DET_OUT_W - 1)) - 1);
  localparam logic signed [PIX_W-1:0] DET_LO = ~DET_HI;
  localparam logic signed [IMG_W-1:0] IMG_HI = IMG_W'((64'sd1 <<< (IMG_OUT_W - 1)) - 1);
  localparam logic signed [IMG_W-1:0] IMG_LO = ~IMG_HI;
  localparam logic signed [DET_OUT_W-1:0] DET_OUT_HI = DET_HI[DET_OUT_W-1:0];
  localparam logic signed [DET_OUT_W-1:0] DET_OUT_LO = DET_LO[DET_OUT_W-1:0];

  // Detector codes by quadrant
  localparam logic [1:0] DET_Q0 = 2'd0;  // x >= 0, y >= 0
  localparam logic [1:0] DET_Q1 = 2'd1;  // x <  0, y >= 0
  localparam logic [1:0] DET_Q2 = 2'd2;  // x <  0, y <  0
  localparam logic [1:0] DET_Q3 = 2'd3;  // x >= 0, y <  0

  // Register indexes
  typedef enum logic [2:0] {
    CFG_ORIGIN0 = 3'd0,
    CFG_ORIGIN1 = 3'd1,
    CFG_ORIGIN2 = 3'd2,
    CFG_ORIGIN3 = 3'd3,
    CFG_ROT01   = 3'd4,
    CFG_ROT23   = 3'd5,
    CFG_SCALE01 = 3'd6,
    CFG_SCALE23 = 3'd7
  } cfg_idx_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ORIGIN_W = 48;

  localparam logic [CFG_DATA_W-1:0] ROT_RESET   = 64'h4000_0000_4000_0000;
  localparam logic [CFG_DATA_W-1:0] SCALE_RESET = 64'h0200_0200_0200_0200;

  // Coefficients of one detector
  typedef struct packed {
    logic signed [FP_W-1:0]   ox;
    logic signed [FP_W-1:0]   oy;
    logic signed [COEF_W-1:0] cos_v;
    logic signed [COEF_W-1:0] sin_v;
    logic        [COEF_W-1:0] kw;
    logic        [COEF_W-1:0] kh;
  } det_coef_t;

  // Word from rotation to scaling
  typedef struct packed {
    logic [1:0]              det;
    logic signed [ROT_W-1:0] rx;
    logic signed [ROT_W-1:0] ry;
    logic [COEF_W-1:0]       kw;
    logic [COEF_W-1:0]       kh;
  } rot_word_t;

  function automatic logic signed [DET_OUT_W-1:0] sat_det(
    input logic signed [PIX_W-1:0] v
  );
    logic signed [DET_OUT_W-1:0] r;
    if (v > DET_HI) begin
      r = DET_OUT_HI;
    end else if (v < DET_LO) begin
      r = DET_OUT_LO;
    end else begin
      r = v[DET_OUT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [IMG_OUT_W-1:0] sat_img(
    input logic signed [IMG_W-1:0] v
  );
    logic signed [IMG_OUT_W-1:0] r;
    if (v > IMG_HI) begin
      r = IMG_HI[IMG_OUT_W-1:0];
    end else if (v < IMG_LO) begin
      r = IMG_LO[IMG_OUT_W-1:0];
    end else begin
      r = v[IMG_OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/focal_plane_to_pixel_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// focal_plane_to_pixel_map
// Maps a focal-plane position to detector and full-image pixel coordinates.
// Pipeline: six register stages, a multiplier stage for rotation and one
//   for pixel scaling; a stall on the output side backs up through them.
// Throughput: one word per cycle while the output side does not stall.
// Reset: synchronous rst_n clears all valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module focal_plane_to_pixel_map import fppm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [FP_W-1:0]      in_fp_x,
  input  logic signed [FP_W-1:0]      in_fp_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_detector_index,
  output logic signed [DET_OUT_W-1:0] out_det_col,
  output logic signed [DET_OUT_W-1:0] out_det_row,
  output logic signed [IMG_OUT_W-1:0] out_image_col,
  output logic signed [IMG_OUT_W-1:0] out_image_row,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  logic [1:0] det_sel;
  det_coef_t  coef;
  logic       rw_valid;
  logic       rw_ready;
  rot_word_t  rw;

  // Register file
  fppm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .det_sel   (det_sel),
    .coef      (coef)
  );

  // Origin subtract and rotation
  fppm_rotate u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .fp_x     (in_fp_x),
    .fp_y     (in_fp_y),
    .det_sel  (det_sel),
    .coef     (coef),
    .rw_valid (rw_valid),
    .rw_ready (rw_ready),
    .rw       (rw)
  );

  // Scaling, rounding and image mapping
  fppm_scale u_scale (
    .clk                (clk),
    .rst_n              (rst_n),
    .rw_valid           (rw_valid),
    .rw_ready           (rw_ready),
    .rw                 (rw),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_detector_index (out_detector_index),
    .out_det_col        (out_det_col),
    .out_det_row        (out_det_row),
    .out_image_col      (out_image_col),
    .out_image_row      (out_image_row)
  );

endmodule

/* sv/fppm_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fppm_cfg_regs
// Configuration register file; hands out the coefficients of one detector.
// ----------------------------------------------------------------------------
module fppm_cfg_regs import fppm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            det_sel,
  output det_coef_t             coef
);

  logic [ORIGIN_W-1:0]   origin_r [4];
  logic [CFG_DATA_W-1:0] rot01_r;
  logic [CFG_DATA_W-1:0] rot23_r;
  logic [CFG_DATA_W-1:0] scl01_r;
  logic [CFG_DATA_W-1:0] scl23_r;

  logic [ORIGIN_W-1:0]   org_sel;
  logic [CFG_DATA_W-1:0] rot_pair;
  logic [CFG_DATA_W-1:0] scl_pair;
  logic [31:0]           rot_half;
  logic [31:0]           scl_half;

  // Always take a word
  assign cfg_ready = 1'b1;

  // Write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r[0] <= '0;
      origin_r[1] <= '0;
      origin_r[2] <= '0;
      origin_r[3] <= '0;
      rot01_r     <= ROT_RESET;
      rot23_r     <= ROT_RESET;
      scl01_r     <= SCALE_RESET;
      scl23_r     <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN0: origin_r[0] <= cfg_data[ORIGIN_W-1:0];
        CFG_ORIGIN1: origin_r[1] <= cfg_data[ORIGIN_W-1:0];
        CFG_ORIGIN2: origin_r[2] <= cfg_data[ORIGIN_W-1:0];
        CFG_ORIGIN3: origin_r[3] <= cfg_data[ORIGIN_W-1:0];
        CFG_ROT01:   rot01_r     <= cfg_data;
        CFG_ROT23:   rot23_r     <= cfg_data;
        CFG_SCALE01: scl01_r     <= cfg_data;
        CFG_SCALE23: scl23_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select the requested detector's fields
  always_comb begin
    org_sel  = origin_r[det_sel];
    rot_pair = det_sel[1] ? rot23_r : rot01_r;
    scl_pair = det_sel[1] ? scl23_r : scl01_r;
    rot_half = det_sel[0] ? rot_pair[63:32] : rot_pair[31:0];
    scl_half = det_sel[0] ? scl_pair[63:32] : scl_pair[31:0];

    coef.ox    = org_sel[FP_W-1:0];
    coef.oy    = org_sel[2*FP_W-1:FP_W];
    coef.sin_v = rot_half[15:0];
    coef.cos_v = rot_half[31:16];
    coef.kw    = scl_half[15:0];
    coef.kh    = scl_half[31:16];
  end

endmodule

/* sv/fppm_rotate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fppm_rotate
// Quadrant pick, origin subtract and rotation: three pipeline stages.
// ----------------------------------------------------------------------------
module fppm_rotate import fppm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [FP_W-1:0] fp_x,
  input  logic signed [FP_W-1:0] fp_y,
  output logic [1:0]             det_sel,
  input  det_coef_t              coef,
  output logic                   rw_valid,
  input  logic                   rw_ready,
  output rot_word_t              rw
);

  // Stage 1: offsets
  logic                     v1_r;
  logic [1:0]               det1_r;
  logic signed [DIFF_W-1:0] dx1_r, dy1_r;
  logic signed [COEF_W-1:0] cos1_r, sin1_r;
  logic [COEF_W-1:0]        kw1_r, kh1_r;
  // Stage 2: trig products
  logic                     v2_r;
  logic [1:0]               det2_r;
  logic signed [PROD_W-1:0] cdx2_r, sdy2_r, cdy2_r, sdx2_r;
  logic [COEF_W-1:0]        kw2_r, kh2_r;
  // Stage 3: rotated offsets
  logic                     v3_r;
  rot_word_t                rw_r;
  rot_word_t                rw_nxt;

  logic rdy1, rdy2, rdy3;

  // A stage advances when it is empty or its successor advances
  assign rdy3     = !v3_r || rw_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Quadrant from sign bits
  assign det_sel = {fp_y[FP_W-1], fp_x[FP_W-1] ^ fp_y[FP_W-1]};

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Stage 1: subtract the detector origin, hold its coefficients
  always_ff @(posedge clk) begin
    if (rdy1) begin
      det1_r <= det_sel;
      dx1_r  <= DIFF_W'(fp_x) - DIFF_W'(coef.ox);
      dy1_r  <= DIFF_W'(fp_y) - DIFF_W'(coef.oy);
      cos1_r <= coef.cos_v;
      sin1_r <= coef.sin_v;
      kw1_r  <= coef.kw;
      kh1_r  <= coef.kh;
    end
  end

  // Stage 2: four trig products
  always_ff @(posedge clk) begin
    if (rdy2) begin
      det2_r <= det1_r;
      cdx2_r <= PROD_W'(cos1_r) * PROD_W'(dx1_r);
      sdy2_r <= PROD_W'(sin1_r) * PROD_W'(dy1_r);
      cdy2_r <= PROD_W'(cos1_r) * PROD_W'(dy1_r);
      sdx2_r <= PROD_W'(sin1_r) * PROD_W'(dx1_r);
      kw2_r  <= kw1_r;
      kh2_r  <= kh1_r;
    end
  end

  // Stage 3: combine into rotated offsets
  always_comb begin
    rw_nxt.det = det2_r;
    rw_nxt.rx  = {cdx2_r[PROD_W-1], cdx2_r} + {sdy2_r[PROD_W-1], sdy2_r};
    rw_nxt.ry  = {cdy2_r[PROD_W-1], cdy2_r} - {sdx2_r[PROD_W-1], sdx2_r};
    rw_nxt.kw  = kw2_r;
    rw_nxt.kh  = kh2_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      rw_r <= rw_nxt;
    end
  end

  assign rw_valid = v3_r;
  assign rw       = rw_r;

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !rdy3 |=> v2_r && $stable(det2_r) && $stable(cdx2_r) && $stable(sdx2_r))
    else $error("stage 2 word changed while stalled");

  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !rw_ready |=> v3_r && $stable(rw_r))
    else $error("rotated word changed while stalled");

endmodule

/* sv/fppm_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fppm_scale
// Pixel scaling, half-pixel rounding, image mapping and saturation:
// three pipeline stages ending in the output register.
// ----------------------------------------------------------------------------
module fppm_scale import fppm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rw_valid,
  output logic                        rw_ready,
  input  rot_word_t                   rw,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_detector_index,
  output logic signed [DET_OUT_W-1:0] out_det_col,
  output logic signed [DET_OUT_W-1:0] out_det_row,
  output logic signed [IMG_OUT_W-1:0] out_image_col,
  output logic signed [IMG_OUT_W-1:0] out_image_row
);

  // Stage 4: scaled offsets
  logic                    v4_r;
  logic [1:0]              det4_r;
  logic signed [SCL_W-1:0] pc4_r, pr4_r;
  // Stage 5: rounded pixel coordinates
  logic                    v5_r;
  logic [1:0]              det5_r;
  logic signed [PIX_W-1:0] col5_r, row5_r;
  logic [RND_W-1:0]        col_rnd, row_rnd;
  // Stage 6: output register
  logic                        v6_r;
  logic [1:0]                  det6_r;
  logic signed [DET_OUT_W-1:0] dcol6_r, drow6_r;
  logic signed [IMG_OUT_W-1:0] icol6_r, irow6_r;
  logic signed [IMG_W-1:0]     col_ext, row_ext, icol_nxt, irow_nxt;

  logic rdy4, rdy5, rdy6;

  // A stage advances when it is empty or its successor advances
  assign rdy6     = !v6_r || out_ready;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rw_ready = rdy4;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_r <= rw_valid;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
      if (rdy6) begin
        v6_r <= v5_r;
      end
    end
  end

  // Stage 4: multiply by reciprocal pixel size
  always_ff @(posedge clk) begin
    if (rdy4) begin
      det4_r <= rw.det;
      pc4_r  <= SCL_W'(rw.rx) * SCL_W'($signed({1'b0, rw.kw}));
      pr4_r  <= SCL_W'(rw.ry) * SCL_W'($signed({1'b0, rw.kh}));
    end
  end

  // Stage 5: drop half a pixel, round to Q.8 (floor after adding half LSB)
  assign col_rnd = {pc4_r[SCL_W-1], pc4_r} + ROUND_ADJ;
  assign row_rnd = {pr4_r[SCL_W-1], pr4_r} + ROUND_ADJ;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      det5_r <= det4_r;
      col5_r <= col_rnd[RND_W-1:FRAC_SH];
      row5_r <= row_rnd[RND_W-1:FRAC_SH];
    end
  end

  // Stage 6: flip and offset into the full image, then clamp
  assign col_ext = {col5_r[PIX_W-1], col5_r};
  assign row_ext = {row5_r[PIX_W-1], row5_r};

  always_comb begin
    case (det5_r)
      DET_Q0: begin
        icol_nxt = IMG_COL_D0 - col_ext;
        irow_nxt = IMG_ROW_D01 - row_ext;
      end
      DET_Q1: begin
        icol_nxt = IMG_COL_D1 - col_ext;
        irow_nxt = IMG_ROW_D01 - row_ext;
      end
      DET_Q2: begin
        icol_nxt = col_ext + IMG_COL_D2;
        irow_nxt = row_ext;
      end
      default: begin
        icol_nxt = col_ext + IMG_COL_D3;
        irow_nxt = row_ext;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      det6_r  <= det5_r;
      dcol6_r <= sat_det(col5_r);
      drow6_r <= sat_det(row5_r);
      icol6_r <= sat_img(icol_nxt);
      irow6_r <= sat_img(irow_nxt);
    end
  end

  assign out_valid          = v6_r;
  assign out_detector_index = det6_r;
  assign out_det_col        = dcol6_r;
  assign out_det_row        = drow6_r;
  assign out_image_col      = icol6_r;
  assign out_image_row      = irow6_r;

  a_s5_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !rdy6 |=> v5_r && $stable(det5_r) && $stable(col5_r) && $stable(row5_r))
    else $error("stage 5 word changed while stalled");

  a_lower_row: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r && (det6_r == DET_Q2 || det6_r == DET_Q3) &&
    drow6_r != DET_OUT_HI && drow6_r != DET_OUT_LO
    |-> irow6_r == {drow6_r[DET_OUT_W-1], drow6_r})
    else $error("lower detector image row differs from detector row");

endmodule

/* verif/focal_plane_to_pixel_map_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// focal_plane_to_pixel_map_checker
// Passive monitor for the focal-plane to pixel map. It tracks every register
// write in a private copy of the detector geometry and predicts the pixel word
// for each accepted position. Each result word is then compared field by
// field with the oldest prediction. It reports the mismatch count and the
// number of words still in flight.
// ----------------------------------------------------------------------------
module focal_plane_to_pixel_map_checker import fppm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic signed [FP_W-1:0]      in_fp_x,
  input  logic signed [FP_W-1:0]      in_fp_y,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [1:0]                  out_detector_index,
  input  logic signed [DET_OUT_W-1:0] out_det_col,
  input  logic signed [DET_OUT_W-1:0] out_det_row,
  input  logic signed [IMG_OUT_W-1:0] out_image_col,
  input  logic signed [IMG_OUT_W-1:0] out_image_row,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  output int                          fail_count,
  output int                          outstanding
);

  typedef struct packed {
    logic [1:0]                  det;
    logic signed [DET_OUT_W-1:0] det_col;
    logic signed [DET_OUT_W-1:0] det_row;
    logic signed [IMG_OUT_W-1:0] image_col;
    logic signed [IMG_OUT_W-1:0] image_row;
  } pixel_word_t;

  // Image placement of each detector, Q.8
  localparam longint COL_FLIP_D0  = longint'((2 * DET_WIDTH + 3 * ROW_PAD - 1) * PIX_ONE);
  localparam longint COL_FLIP_D1  = longint'((DET_WIDTH + ROW_PAD - 1) * PIX_ONE);
  localparam longint COL_SHIFT_D2 = longint'(ROW_PAD * PIX_ONE);
  localparam longint COL_SHIFT_D3 = longint'((DET_WIDTH + 3 * ROW_PAD) * PIX_ONE);
  localparam longint ROW_FLIP_D01 = longint'((2 * DET_HEIGHT + 2 * DARK_COLS - 1) * PIX_ONE);

  // Shadow copy of the detector geometry; pairs indexed by detector bit 1
  logic [ORIGIN_W-1:0]   origin_q   [4];
  logic [CFG_DATA_W-1:0] rotation_q [2];
  logic [CFG_DATA_W-1:0] scale_q    [2];

  pixel_word_t expected_pixels[$];
  int          mismatch_count = 0;
  int          words_in_flight = 0;

  assign fail_count  = mismatch_count;
  assign outstanding = words_in_flight;

  function automatic longint clamp_signed(longint v, int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -(64'sd1 <<< (w - 1));
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Drop half a pixel from a Q.39 value and round to Q.8, ties upward
  function automatic longint to_q8_pixel(longint q39);
    return (q39 - (64'sd1 <<< 38) + (64'sd1 <<< 30)) >>> 31;
  endfunction

  function automatic pixel_word_t map_position(logic signed [FP_W-1:0] fx,
                                               logic signed [FP_W-1:0] fy);
    logic [1:0]          det;
    logic [ORIGIN_W-1:0] org;
    logic [31:0]         rot;
    logic [31:0]         scl;
    longint              x, y, ox, oy, c, s, kw, kh, dx, dy, rx, ry;
    longint              col, row, icol, irow;
    pixel_word_t         w;
    x = longint'(fx);
    y = longint'(fy);
    // Pick the detector from the quadrant
    if (x >= 0) begin
      det = (y >= 0) ? DET_Q0 : DET_Q3;
    end else begin
      det = (y >= 0) ? DET_Q1 : DET_Q2;
    end
    org = origin_q[det];
    rot = det[0] ? rotation_q[det[1]][63:32] : rotation_q[det[1]][31:0];
    scl = det[0] ? scale_q[det[1]][63:32] : scale_q[det[1]][31:0];
    ox = longint'($signed(org[23:0]));
    oy = longint'($signed(org[47:24]));
    s  = longint'($signed(rot[15:0]));
    c  = longint'($signed(rot[31:16]));
    kw = longint'(scl[15:0]);
    kh = longint'(scl[31:16]);
    // Shift to the detector origin, rotate, scale to pixels
    dx  = x - ox;
    dy  = y - oy;
    rx  = c * dx + s * dy;
    ry  = c * dy - s * dx;
    col = to_q8_pixel(rx * kw);
    row = to_q8_pixel(ry * kh);
    // Place in the full image from the unclamped detector values
    case (det)
      DET_Q0: begin
        icol = COL_FLIP_D0 - col;
        irow = ROW_FLIP_D01 - row;
      end
      DET_Q1: begin
        icol = COL_FLIP_D1 - col;
        irow = ROW_FLIP_D01 - row;
      end
      DET_Q2: begin
        icol = col + COL_SHIFT_D2;
        irow = row;
      end
      default: begin
        icol = col + COL_SHIFT_D3;
        irow = row;
      end
    endcase
    w.det       = det;
    w.det_col   = DET_OUT_W'(clamp_signed(col, DET_OUT_W));
    w.det_row   = DET_OUT_W'(clamp_signed(row, DET_OUT_W));
    w.image_col = IMG_OUT_W'(clamp_signed(icol, IMG_OUT_W));
    w.image_row = IMG_OUT_W'(clamp_signed(irow, IMG_OUT_W));
    return w;
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_word_t want;
    if (!rst_n) begin
      // Load register defaults and forget any prediction
      for (int i = 0; i < 4; i++) begin
        origin_q[i] = '0;
      end
      rotation_q[0] = ROT_RESET;
      rotation_q[1] = ROT_RESET;
      scale_q[0]    = SCALE_RESET;
      scale_q[1]    = SCALE_RESET;
      expected_pixels.delete();
      words_in_flight = 0;
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ORIGIN0: origin_q[0]   = cfg_data[ORIGIN_W-1:0];
          CFG_ORIGIN1: origin_q[1]   = cfg_data[ORIGIN_W-1:0];
          CFG_ORIGIN2: origin_q[2]   = cfg_data[ORIGIN_W-1:0];
          CFG_ORIGIN3: origin_q[3]   = cfg_data[ORIGIN_W-1:0];
          CFG_ROT01:   rotation_q[0] = cfg_data;
          CFG_ROT23:   rotation_q[1] = cfg_data;
          CFG_SCALE01: scale_q[0]    = cfg_data;
          CFG_SCALE23: scale_q[1]    = cfg_data;
          default: ;
        endcase
      end
      // Compare each result word with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: result word with nothing expected, actual det %0d col %0d row %0d",
                   $time, out_detector_index, out_det_col, out_det_row);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          words_in_flight--;
          check_field("detector_index", longint'(want.det), longint'(out_detector_index));
          check_field("det_col", longint'(want.det_col), longint'(out_det_col));
          check_field("det_row", longint'(want.det_row), longint'(out_det_row));
          check_field("image_col", longint'(want.image_col), longint'(out_image_col));
          check_field("image_row", longint'(want.image_row), longint'(out_image_row));
        end
      end
      // Predict each accepted position
      if (in_valid && in_ready) begin
        expected_pixels.push_back(map_position(in_fp_x, in_fp_y));
        words_in_flight++;
      end
    end
  end

endmodule

/* verif/focal_plane_to_pixel_map_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// focal_plane_to_pixel_map_tb
// Stimulus and verdict for the focal-plane to pixel map. Runs the reset
// geometry, two corner-case geometries (largest and smallest coefficients,
// zero reciprocal scale, origins at the range limits) and three random ones.
// All get random positions, the first two field extremes first, under changing
// sender idles and receiver stalls; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module focal_plane_to_pixel_map_tb;
  import fppm_pkg::*;

  localparam logic signed [FP_W-1:0] FP_MAX = {1'b0, {(FP_W - 1){1'b1}}};
  localparam logic signed [FP_W-1:0] FP_MIN = {1'b1, {(FP_W - 1){1'b0}}};
  localparam int POINTS_PER_SETTING = 200;
  localparam int NUM_SETTINGS       = 6;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [FP_W-1:0]      in_fp_x;
  logic signed [FP_W-1:0]      in_fp_y;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  out_detector_index;
  logic signed [DET_OUT_W-1:0] out_det_col;
  logic signed [DET_OUT_W-1:0] out_det_row;
  logic signed [IMG_OUT_W-1:0] out_image_col;
  logic signed [IMG_OUT_W-1:0] out_image_row;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;

  int mismatch_count;
  int words_in_flight;
  int sender_idle_pct    = 37;
  int receiver_stall_pct = 67;

  focal_plane_to_pixel_map dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_fp_x            (in_fp_x),
    .in_fp_y            (in_fp_y),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_detector_index (out_detector_index),
    .out_det_col        (out_det_col),
    .out_det_row        (out_det_row),
    .out_image_col      (out_image_col),
    .out_image_row      (out_image_row),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  focal_plane_to_pixel_map_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_fp_x            (in_fp_x),
    .in_fp_y            (in_fp_y),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_detector_index (out_detector_index),
    .out_det_col        (out_det_col),
    .out_det_row        (out_det_row),
    .out_image_col      (out_image_col),
    .out_image_row      (out_image_row),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (mismatch_count),
    .outstanding        (words_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Offer one position word and hold it until accepted
  task automatic send_point(input logic signed [FP_W-1:0] x,
                            input logic signed [FP_W-1:0] y);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_fp_x  <= x;
    in_fp_y  <= y;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold one register write until accepted; valid stays high for the next
  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_detectors(input logic [ORIGIN_W-1:0] o0, o1, o2, o3,
                                   input logic [CFG_DATA_W-1:0] r01, r23, s01, s23);
    write_register(CFG_ORIGIN0, CFG_DATA_W'(o0));
    write_register(CFG_ORIGIN1, CFG_DATA_W'(o1));
    write_register(CFG_ORIGIN2, CFG_DATA_W'(o2));
    write_register(CFG_ORIGIN3, CFG_DATA_W'(o3));
    write_register(CFG_ROT01, r01);
    write_register(CFG_ROT23, r23);
    write_register(CFG_SCALE01, s01);
    write_register(CFG_SCALE23, s23);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering words and wait for every prediction to be met
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (words_in_flight != 0) @(negedge clk);
  endtask

  // Quadrant boundaries, range corners and alternating bit patterns
  task automatic send_field_extremes();
    send_point('0, '0);
    send_point(-24'sd1, '0);
    send_point(-24'sd1, -24'sd1);
    send_point('0, -24'sd1);
    send_point(FP_MAX, FP_MAX);
    send_point(FP_MIN, FP_MAX);
    send_point(FP_MIN, FP_MIN);
    send_point(FP_MAX, FP_MIN);
    send_point(FP_MAX, '0);
    send_point('0, FP_MIN);
    send_point(24'sh555555, 24'shAAAAAA);
    send_point(24'shAAAAAA, 24'sh555555);
  endtask

  // Random reciprocal pixel sizes over many magnitudes, height over width
  function automatic logic [31:0] random_scale_pair();
    logic [15:0] kw;
    logic [15:0] kh;
    kw = 16'($urandom) >> $urandom_range(15);
    kh = 16'($urandom) >> $urandom_range(15);
    return {kh, kw};
  endfunction

  initial begin : stimulus
    logic signed [FP_W-1:0] x;
    logic signed [FP_W-1:0] y;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_fp_x   = '0;
    in_fp_y   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
      // Idle profile: sender light and receiver heavy, then swapped, then none
      sender_idle_pct    = (setting < 2) ? 37 : ((setting < 4) ? 67 : 0);
      receiver_stall_pct = (setting < 2) ? 67 : ((setting < 4) ? 37 : 0);

      // Reprogram the geometry only with the pipeline empty
      if (setting != 0) begin
        drain_pipeline();
        case (setting)
          1: program_detectors({24'h800000, 24'h800000}, {24'h800000, 24'h7FFFFF},
                               {24'h7FFFFF, 24'h7FFFFF}, {24'h7FFFFF, 24'h800000},
                               {2{32'h7FFF_8000}}, {2{32'h8000_7FFF}},
                               '1, '1);
          2: program_detectors('1, '1, '1, '1,
                               64'h8000_8000_8000_8000, 64'h7FFF_7FFF_0000_0000,
                               '0, 64'hFFFF_0000_0000_FFFF);
          default: program_detectors(ORIGIN_W'({$urandom, $urandom}),
                                     ORIGIN_W'({$urandom, $urandom}),
                                     ORIGIN_W'({$urandom, $urandom}),
                                     ORIGIN_W'({$urandom, $urandom}),
                                     {$urandom, $urandom}, {$urandom, $urandom},
                                     {random_scale_pair(), random_scale_pair()},
                                     {random_scale_pair(), random_scale_pair()});
        endcase
      end

      if (setting < 2) begin
        send_field_extremes();
      end
      // Exact half-pixel ties under the identity geometry
      if (setting == 0) begin
        send_point(24'sh000080, 24'sh000180);
        send_point(-24'sh000080, -24'sh000180);
      end

      // Random positions, half of them pulled toward the center
      repeat (POINTS_PER_SETTING) begin
        x = FP_W'($urandom);
        y = FP_W'($urandom);
        if ($urandom_range(1)) begin
          x = x >>> $urandom_range(20);
          y = y >>> $urandom_range(20);
        end
        send_point(x, y);
      end
    end

    drain_pipeline();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Abort a hung run
  initial begin : watchdog
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
